// ----- design/rvex_pkg.sv -----
// ----------------------------------------------------------------------------
// rvex_pkg
// types, opcode codes and stage functions shared by the execute unit
// ----------------------------------------------------------------------------
package rvex_pkg;

  // major opcodes, instruction bits 6..2
  localparam logic [4:0] OPC_LOAD     = 5'd0;
  localparam logic [4:0] OPC_MISC_MEM = 5'd3;
  localparam logic [4:0] OPC_OP_IMM   = 5'd4;
  localparam logic [4:0] OPC_AUIPC    = 5'd5;
  localparam logic [4:0] OPC_STORE    = 5'd8;
  localparam logic [4:0] OPC_OP       = 5'd12;
  localparam logic [4:0] OPC_LUI      = 5'd13;
  localparam logic [4:0] OPC_BRANCH   = 5'd24;
  localparam logic [4:0] OPC_JALR     = 5'd25;
  localparam logic [4:0] OPC_JAL      = 5'd27;
  localparam logic [4:0] OPC_SYSTEM   = 5'd28;

  // alu funct3 codes
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;
  // muldiv funct3 codes
  localparam logic [2:0] F3_MUL    = 3'd0;
  localparam logic [2:0] F3_MULH   = 3'd1;
  localparam logic [2:0] F3_MULHSU = 3'd2;
  localparam logic [2:0] F3_MULHU  = 3'd3;
  localparam logic [2:0] F3_DIV    = 3'd4;
  localparam logic [2:0] F3_DIVU   = 3'd5;
  localparam logic [2:0] F3_REM    = 3'd6;
  localparam logic [2:0] F3_REMU   = 3'd7;
  // csr funct3 codes
  localparam logic [2:0] F3_PRIV  = 3'd0;
  localparam logic [2:0] F3_CSRRW = 3'd1;
  localparam logic [2:0] F3_CSRRS = 3'd2;
  localparam logic [2:0] F3_CSRRC = 3'd3;
  localparam logic [2:0] F3_CSRWI = 3'd5;
  localparam logic [2:0] F3_CSRSI = 3'd6;
  localparam logic [2:0] F3_CSRCI = 3'd7;
  localparam logic [6:0] F7_MULDIV = 7'd1;
  // branch compare kinds, funct3 bits 2..1
  localparam logic [1:0] BR_EQ   = 2'd0;
  localparam logic [1:0] BR_NONE = 2'd1;
  localparam logic [1:0] BR_LT   = 2'd2;
  localparam logic [1:0] BR_LTU  = 2'd3;

  localparam int unsigned DivBitsPerStage = 2;
  localparam int unsigned DivStages       = 32 / DivBitsPerStage;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_MUL,
    KIND_DIV
  } kind_e;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] pc;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [63:0] csr_in;
  } in_t;

  // item in flight; quo/dvsr double as multiplier operands
  typedef struct packed {
    kind_e       kind;
    logic [31:0] res;
    logic [31:0] sdata;
    logic        taken;
    logic [31:0] target;
    logic [63:0] csr;
    logic        err;
    logic [31:0] rem;
    logic [31:0] quo;
    logic [31:0] dvsr;
    logic        a_sgn;
    logic        b_sgn;
    logic        mul_hi;
    logic        want_rem;
    logic        neg_res;
  } mid_t;

  typedef struct packed {
    logic [63:0] csr_out;
    logic [31:0] jump_target;
    logic        br_taken;
    logic [31:0] store_data;
    logic [31:0] result;
    logic        error;
  } out_t;

  function automatic mid_t mul_fn(mid_t x);
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic signed [65:0] prod;
    mid_t               y;
    y    = x;
    ma   = $signed({x.a_sgn & x.quo[31], x.quo});
    mb   = $signed({x.b_sgn & x.dvsr[31], x.dvsr});
    prod = ma * mb;
    if (x.kind == KIND_MUL) begin
      y.res  = x.mul_hi ? prod[63:32] : prod[31:0];
      y.kind = KIND_PLAIN;
    end
    return y;
  endfunction

  // restoring division, one quotient bit
  function automatic mid_t div_bit(mid_t x);
    logic [32:0] sh;
    logic [32:0] diff;
    mid_t        y;
    y    = x;
    sh   = {x.rem, x.quo[31]};
    diff = sh - {1'b0, x.dvsr};
    if (!diff[32]) begin
      y.rem = diff[31:0];
      y.quo = {x.quo[30:0], 1'b1};
    end else begin
      y.rem = sh[31:0];
      y.quo = {x.quo[30:0], 1'b0};
    end
    return y;
  endfunction

  function automatic mid_t div_fn(mid_t x);
    mid_t y;
    y = x;
    if (x.kind == KIND_DIV) begin
      for (int i = 0; i < DivBitsPerStage; i++) begin
        y = div_bit(y);
      end
    end
    return y;
  endfunction

  function automatic out_t finish_fn(mid_t x);
    logic [31:0] v;
    out_t        o;
    v = x.want_rem ? x.rem : x.quo;
    if (x.neg_res) begin
      v = 32'd0 - v;
    end
    o.result      = (x.kind == KIND_DIV) ? v : x.res;
    o.store_data  = x.sdata;
    o.br_taken    = x.taken;
    o.jump_target = x.target;
    o.csr_out     = x.csr;
    o.error       = x.err;
    return o;
  endfunction

endpackage

// ----- design/rvex_decode.sv -----
// ----------------------------------------------------------------------------
// rvex_decode
// field decode, alu, branch, jump and csr results, mul/div setup
// ----------------------------------------------------------------------------
module rvex_decode import rvex_pkg::*; (
  input  in_t  item_i,
  output mid_t mid_o
);

  logic [31:0] ins;
  logic [31:0] a;
  logic [31:0] b;
  logic [4:0]  opc;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [4:0]  rs1f;
  logic        alt;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic        cond;
  logic        sgn;

  function automatic logic [31:0] alu(logic [2:0] f, logic alt_i, logic [31:0] x,
                                      logic [31:0] y, logic is_imm);
    logic [4:0] sh;
    sh = y[4:0];
    case (f)
      F3_ADD:  alu = (alt_i && !is_imm) ? x - y : x + y;
      F3_SLL:  alu = x << sh;
      F3_SLT:  alu = {31'd0, $signed(x) < $signed(y)};
      F3_SLTU: alu = {31'd0, x < y};
      F3_XOR:  alu = x ^ y;
      F3_SR:   alu = alt_i ? 32'($signed(x) >>> sh) : x >> sh;
      F3_OR:   alu = x | y;
      default: alu = x & y;
    endcase
  endfunction

  assign ins   = item_i.instruction;
  assign a     = item_i.operand_a;
  assign b     = item_i.operand_b;
  assign opc   = ins[6:2];
  assign f3    = ins[14:12];
  assign f7    = ins[31:25];
  assign rs1f  = ins[19:15];
  assign alt   = ins[30];
  assign imm_i = {{20{ins[31]}}, ins[31:20]};
  assign imm_s = {{20{ins[31]}}, ins[31:25], ins[11:7]};

  always_comb begin
    mid_o      = '0;
    mid_o.kind = KIND_PLAIN;
    cond       = 1'b0;
    sgn        = 1'b0;
    unique case (opc)
      OPC_LOAD:     mid_o.res = a + imm_i;
      OPC_MISC_MEM: mid_o.res = '1;
      OPC_OP_IMM:   mid_o.res = alu(f3, alt, a, imm_i, 1'b1);
      OPC_AUIPC:    mid_o.res = item_i.pc + {ins[31:12], 12'd0};
      OPC_STORE: begin
        mid_o.res   = a + imm_s;
        mid_o.sdata = b;
      end
      OPC_OP: begin
        if (f7 != F7_MULDIV) begin
          mid_o.res = alu(f3, alt, a, b, 1'b0);
        end else if (!f3[2]) begin
          mid_o.kind   = KIND_MUL;
          mid_o.quo    = a;
          mid_o.dvsr   = b;
          mid_o.a_sgn  = (f3 == F3_MULH) || (f3 == F3_MULHSU);
          mid_o.b_sgn  = (f3 == F3_MULH);
          mid_o.mul_hi = (f3 != F3_MUL);
        end else if (b == 32'd0) begin
          // divide by zero: all ones for the quotient, dividend for the remainder
          mid_o.res = f3[1] ? a : '1;
        end else begin
          sgn            = !f3[0];
          mid_o.kind     = KIND_DIV;
          mid_o.quo      = (sgn && a[31]) ? 32'd0 - a : a;
          mid_o.dvsr     = (sgn && b[31]) ? 32'd0 - b : b;
          mid_o.want_rem = f3[1];
          mid_o.neg_res  = sgn && (f3[1] ? a[31] : (a[31] ^ b[31]));
        end
      end
      OPC_LUI:      mid_o.res = {ins[31:12], 12'd0};
      OPC_BRANCH: begin
        case (f3[2:1])
          BR_EQ:   cond = (a == b);
          BR_LT:   cond = $signed(a) < $signed(b);
          BR_LTU:  cond = a < b;
          default: cond = 1'b0;
        endcase
        mid_o.taken = (f3[2:1] != BR_NONE) && (cond ^ f3[0]);
      end
      OPC_JALR: begin
        mid_o.res    = item_i.pc + 32'd4;
        mid_o.target = (a + imm_i) & ~32'd1;
      end
      OPC_JAL:      mid_o.res = item_i.pc + 32'd4;
      OPC_SYSTEM: begin
        case (f3)
          F3_CSRRW: mid_o.csr = {32'd0, a};
          F3_CSRRS: mid_o.csr = (rs1f != 5'd0) ? item_i.csr_in | {32'd0, a} : item_i.csr_in;
          F3_CSRRC: mid_o.csr = item_i.csr_in & ~{32'd0, a};
          F3_CSRWI: mid_o.csr = {59'd0, rs1f};
          F3_CSRSI: mid_o.csr = item_i.csr_in | {59'd0, rs1f};
          F3_CSRCI: mid_o.csr = item_i.csr_in & ~{59'd0, rs1f};
          default:  mid_o.err = 1'b1;
        endcase
      end
      default:      mid_o.err = 1'b1;
    endcase
  end

endmodule

// ----- design/rv32im_execute_unit.sv -----
// ----------------------------------------------------------------------------
// rv32im_execute_unit
// pipelined rv32im execute stage with multiplier and radix-2 divider
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out, in order. A new instruction can
// be taken every cycle while the output is not held; its result is offered
// once the input transaction has passed 19 registers: an input register, a
// decode stage, 16 divider stages that each retire two quotient bits (the first
// of them also holds the 33x33 multiplier), and the output register.
// Every instruction walks the full depth so results never reorder. When the
// output holds a transaction that is not taken, the whole pipeline freezes and
// s_axis_tready_o drops; nothing is lost or duplicated.
module rv32im_execute_unit import rvex_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // instruction[31:0], pc[63:32], operand_a[95:64], operand_b[127:96],
  // csr_in[191:128]
  input  logic [191:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // result[31:0], store_data[63:32], br_taken[64], jump_target[96:65],
  // csr_out[160:97], error[161], zero fill [167:162]
  output logic [167:0] m_axis_tdata_o
);

  logic advance;

  // input register
  logic in_vld_q;
  in_t  in_q;

  // decode output and divider stages
  mid_t dec_mid;
  logic [DivStages:0] mid_vld_q;
  mid_t               mid_q [DivStages+1];

  // output register
  logic out_vld_q;
  out_t out_q;

  // the pipeline moves as one; it stops only when the output is held
  assign advance         = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (advance) begin
      in_vld_q  <= s_axis_tvalid_i;
      mid_vld_q <= {mid_vld_q[DivStages-1:0], in_vld_q};
      out_vld_q <= mid_vld_q[DivStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      in_q     <= in_t'({s_axis_tdata_i[31:0], s_axis_tdata_i[63:32],
                         s_axis_tdata_i[95:64], s_axis_tdata_i[127:96],
                         s_axis_tdata_i[191:128]});
      mid_q[0] <= dec_mid;
      // first stage also runs the multiplier; each stage retires two quotient bits
      mid_q[1] <= div_fn(mul_fn(mid_q[0]));
      for (int k = 1; k < DivStages; k++) begin
        mid_q[k+1] <= div_fn(mid_q[k]);
      end
      out_q    <= finish_fn(mid_q[DivStages]);
    end
  end

  rvex_decode u_decode (
    .item_i (in_q),
    .mid_o  (dec_mid)
  );

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'd0, out_q.error, out_q.csr_out, out_q.jump_target,
                            out_q.br_taken, out_q.store_data, out_q.result};

endmodule

// ----- design/rvex_checker.sv -----
// ----------------------------------------------------------------------------
// rvex_checker
// port-level checks on the execute unit, bound to the top level
// ----------------------------------------------------------------------------
module rvex_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tready_o,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [167:0] m_axis_tdata_o
);

  // a held output keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("output changed while stalled");

  // an empty output never blocks the input
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output");

  // errors carry a zero result, no csr update and no branch
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[161] |->
      m_axis_tdata_o[31:0] == 32'd0 && m_axis_tdata_o[160:97] == 64'd0 &&
      !m_axis_tdata_o[64])
    else $error("error result not clean");

  // jump target is halfword aligned
  a_target_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !m_axis_tdata_o[65])
    else $error("jump target bit 0 set");

  // fill bits stay zero
  a_fill_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[167:162] == 6'd0)
    else $error("fill bits not zero");

endmodule

bind rv32im_execute_unit rvex_checker u_rvex_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- test/tb_rv32im_execute_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32im_execute_unit
// self-checking bench: random and directed rv32im instructions through the
// execute unit, each result compared with a behavioral prediction
// ----------------------------------------------------------------------------
module tb_rv32im_execute_unit import rvex_pkg::*; ();

  localparam int unsigned Latency   = 18;
  localparam int unsigned NumRandom = 900;

  logic         clk;
  logic         rst_n;
  logic         s_valid;
  logic         s_ready;
  logic [191:0] s_data;
  logic         m_valid;
  logic         m_ready;
  logic [167:0] m_data;

  in_t  pending_instrs[$];
  out_t expected_results[$];
  int   fail_count;
  bit   stim_done;
  bit   s_fire;
  int   burst_left;
  int   gap_left;
  int   hold_off;

  rv32im_execute_unit i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic logic [31:0] imm12(logic [11:0] v);
    return {{20{v[11]}}, v};
  endfunction

  // tdata layout: instruction lowest, csr_in highest
  function automatic logic [191:0] pack_in(in_t it);
    return {it.csr_in, it.operand_b, it.operand_a, it.pc, it.instruction};
  endfunction

  function automatic in_t unpack_in(logic [191:0] d);
    in_t it;
    it.instruction = d[31:0];
    it.pc          = d[63:32];
    it.operand_a   = d[95:64];
    it.operand_b   = d[127:96];
    it.csr_in      = d[191:128];
    return it;
  endfunction

  function automatic logic [31:0] alu_value(logic [2:0] f3, logic alt, logic [31:0] a,
                                            logic [31:0] b, logic is_imm);
    logic [4:0] sh;
    sh = b[4:0];
    case (f3)
      F3_ADD:  return (alt && !is_imm) ? a - b : a + b;
      F3_SLL:  return a << sh;
      F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
      F3_SLTU: return {31'd0, a < b};
      F3_XOR:  return a ^ b;
      F3_SR:   return alt ? 32'($signed(a) >>> sh) : a >> sh;
      F3_OR:   return a | b;
      default: return a & b;
    endcase
  endfunction

  function automatic logic [31:0] muldiv_value(logic [2:0] f3, logic [31:0] a,
                                               logic [31:0] b);
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] p;
    logic [31:0] ma;
    logic [31:0] mb;
    logic [31:0] q;
    sa = {{32{a[31]}}, a};
    sb = {{32{b[31]}}, b};
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (f3)
      F3_MUL:    begin p = sa * sb; return p[31:0]; end
      F3_MULH:   begin p = sa * sb; return p[63:32]; end
      F3_MULHSU: begin p = sa * {32'd0, b}; return p[63:32]; end
      F3_MULHU:  begin p = {32'd0, a} * {32'd0, b}; return p[63:32]; end
      F3_DIV: begin
        if (b == 0) return '1;
        if (a == 32'h8000_0000 && b == '1) return a;
        q = ma / mb;
        return (a[31] ^ b[31]) ? -q : q;
      end
      F3_DIVU:   return (b == 0) ? '1 : a / b;
      F3_REM: begin
        if (b == 0) return a;
        if (a == 32'h8000_0000 && b == '1) return '0;
        q = ma % mb;
        return a[31] ? -q : q;
      end
      default:   return (b == 0) ? a : a % b;
    endcase
  endfunction

  function automatic out_t execute_instr(in_t it);
    out_t        o;
    logic [31:0] ins;
    logic [2:0]  f3;
    logic        cond;
    logic [63:0] a64;
    logic [63:0] z64;
    ins  = it.instruction;
    f3   = ins[14:12];
    a64  = {32'd0, it.operand_a};
    z64  = {59'd0, ins[19:15]};
    o    = '0;
    cond = 1'b0;
    case (ins[6:2])
      OPC_LOAD:     o.result = it.operand_a + imm12(ins[31:20]);
      OPC_MISC_MEM: o.result = '1;
      OPC_OP_IMM:   o.result = alu_value(f3, ins[30], it.operand_a, imm12(ins[31:20]), 1'b1);
      OPC_AUIPC:    o.result = it.pc + {ins[31:12], 12'd0};
      OPC_STORE: begin
        o.result     = it.operand_a + imm12({ins[31:25], ins[11:7]});
        o.store_data = it.operand_b;
      end
      OPC_OP: o.result = (ins[31:25] == F7_MULDIV)
          ? muldiv_value(f3, it.operand_a, it.operand_b)
          : alu_value(f3, ins[30], it.operand_a, it.operand_b, 1'b0);
      OPC_LUI: o.result = {ins[31:12], 12'd0};
      OPC_BRANCH: begin
        case (f3[2:1])
          BR_EQ:   cond = it.operand_a == it.operand_b;
          BR_LT:   cond = $signed(it.operand_a) < $signed(it.operand_b);
          BR_LTU:  cond = it.operand_a < it.operand_b;
          default: cond = 1'b0;
        endcase
        if (f3[2:1] != BR_NONE) o.br_taken = cond ^ f3[0];
      end
      OPC_JALR: begin
        o.result      = it.pc + 32'd4;
        o.jump_target = (it.operand_a + imm12(ins[31:20])) & ~32'd1;
      end
      OPC_JAL: o.result = it.pc + 32'd4;
      OPC_SYSTEM: begin
        case (f3)
          F3_CSRRW: o.csr_out = a64;
          F3_CSRRS: o.csr_out = (ins[19:15] != 0) ? (it.csr_in | a64) : it.csr_in;
          F3_CSRRC: o.csr_out = it.csr_in & ~a64;
          F3_CSRWI: o.csr_out = z64;
          F3_CSRSI: o.csr_out = it.csr_in | z64;
          F3_CSRCI: o.csr_out = it.csr_in & ~z64;
          default:  o.error = 1'b1;
        endcase
      end
      default: o.error = 1'b1;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] special_word();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t random_instr();
    in_t         it;
    logic [4:0]  opc;
    logic [31:0] ins;
    int          pick;
    logic [4:0]  known[11];
    known = '{OPC_LOAD, OPC_MISC_MEM, OPC_OP_IMM, OPC_AUIPC, OPC_STORE, OPC_OP,
              OPC_LUI, OPC_BRANCH, OPC_JALR, OPC_JAL, OPC_SYSTEM};
    ins  = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 10) opc = 5'($urandom);
    else if (pick < 45) opc = OPC_OP;
    else opc = known[$urandom_range(0, 10)];
    ins[6:2] = opc;
    // bias multiply/divide and plain funct7 encodings
    if (opc == OPC_OP && $urandom_range(0, 3) != 0)
      ins[31:25] = $urandom_range(0, 1) ? F7_MULDIV : {1'b0, ins[30], 5'd0};
    if ($urandom_range(0, 7) == 0) ins[19:15] = 5'd0;
    it.instruction = ins;
    it.pc          = $urandom;
    it.operand_a   = special_word();
    it.operand_b   = ($urandom_range(0, 9) == 0) ? it.operand_a : special_word();
    if ($urandom_range(0, 9) == 0) it.operand_b = 32'hFFFF_FFFF;
    it.csr_in      = {$urandom, $urandom};
    return it;
  endfunction

  function automatic in_t make_instr(logic [31:0] ins, logic [31:0] a, logic [31:0] b);
    in_t it;
    it.instruction = ins;
    it.pc          = 32'hFFFF_FFFC;
    it.operand_a   = a;
    it.operand_b   = b;
    it.csr_in      = 64'hFFFF_FFFF_FFFF_FFFF;
    return it;
  endfunction

  // stimulus: directed corner cases first, then random mix
  initial begin
    logic [31:0] rop;
    rop = {F7_MULDIV, 5'd2, 5'd1, 3'd0, 5'd3, OPC_OP, 2'b11};
    pending_instrs.push_back(make_instr(rop | (F3_DIV << 12), 32'h8000_0000, '1));
    pending_instrs.push_back(make_instr(rop | (F3_REM << 12), 32'h8000_0000, '1));
    pending_instrs.push_back(make_instr(rop | (F3_DIV << 12), 32'h1234, 0));
    pending_instrs.push_back(make_instr(rop | (F3_DIVU << 12), 32'h1234, 0));
    pending_instrs.push_back(make_instr(rop | (F3_REM << 12), 32'h8765_4321, 0));
    pending_instrs.push_back(make_instr(rop | (F3_REMU << 12), 32'hFFFF_FFFF, 0));
    pending_instrs.push_back(make_instr(rop | (F3_REMU << 12), 32'hFFFF_FFFF, 32'h7));
    pending_instrs.push_back(make_instr(rop | (F3_MULH << 12), 32'h8000_0000, 32'h8000_0000));
    pending_instrs.push_back(make_instr(rop | (F3_MULHSU << 12), '1, '1));
    pending_instrs.push_back(make_instr(rop | (F3_MULHU << 12), '1, '1));
    pending_instrs.push_back(make_instr(rop | (F3_MUL << 12), '1, '1));
    pending_instrs.push_back(make_instr({7'h20, 5'd2, 5'd1, F3_SR, 5'd3, OPC_OP, 2'b11},
                                        32'h8000_0000, 32'd31));
    pending_instrs.push_back(make_instr({7'h7E, 5'd2, 5'd1, F3_ADD, 5'd3, OPC_OP, 2'b00},
                                        32'd0, 32'd1));
    pending_instrs.push_back(make_instr({12'h41F, 5'd1, F3_SR, 5'd3, OPC_OP_IMM, 2'b11},
                                        32'h8000_0000, 0));
    pending_instrs.push_back(make_instr({12'h800, 5'd1, F3_ADD, 5'd3, OPC_LOAD, 2'b11},
                                        32'h0, 0));
    pending_instrs.push_back(make_instr({7'h7F, 5'd2, 5'd1, 3'd2, 5'h1F, OPC_STORE, 2'b11},
                                        32'h0, '1));
    pending_instrs.push_back(make_instr({12'h7FF, 5'd1, 3'd0, 5'd1, OPC_JALR, 2'b11},
                                        32'h0, 0));
    pending_instrs.push_back(make_instr({20'hFFFFF, 5'd1, OPC_JAL, 2'b11}, 0, 0));
    pending_instrs.push_back(make_instr({20'hFFFFF, 5'd1, OPC_AUIPC, 2'b11}, 0, 0));
    pending_instrs.push_back(make_instr({20'hFFFFF, 5'd1, OPC_LUI, 2'b11}, 0, 0));
    pending_instrs.push_back(make_instr({7'd0, 5'd2, 5'd1, 3'd2, 5'd0, OPC_BRANCH, 2'b11},
                                        5, 5));
    pending_instrs.push_back(make_instr({12'd0, 5'd0, 3'd0, 5'd0, OPC_MISC_MEM, 2'b11}, 0, 0));
    pending_instrs.push_back(make_instr({12'd1, 5'd0, F3_PRIV, 5'd0, OPC_SYSTEM, 2'b11}, 0, 0));
    pending_instrs.push_back(make_instr({12'h300, 5'd0, F3_CSRRS, 5'd1, OPC_SYSTEM, 2'b11},
                                        '1, 0));
    pending_instrs.push_back(make_instr({12'h300, 5'd31, F3_CSRCI, 5'd1, OPC_SYSTEM, 2'b11},
                                        0, 0));
    pending_instrs.push_back(make_instr({25'd0, 5'd1, 2'b11}, 0, 0));
    for (int i = 0; i < NumRandom; i++) pending_instrs.push_back(random_instr());
    stim_done = 1'b1;
  end

  // input transaction seen at the rising edge, used by the sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_fire <= 1'b0;
    end else begin
      s_fire <= s_valid && s_ready;
    end
  end

  // sender: bursts with random gaps
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      s_valid    <= 1'b0;
      s_data     <= '0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_valid || s_fire) begin
      if (s_valid) void'(pending_instrs.pop_front());
      if (gap_left > 0) begin
        s_valid  <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_instrs.size() > 0) begin
        s_valid <= 1'b1;
        s_data  <= pack_in(pending_instrs[0]);
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // receiver: own stall pattern plus one long hold-off to fill the pipeline
  always @(negedge clk or negedge rst_n) begin
    if (!rst_n) begin
      m_ready  <= 1'b0;
      hold_off <= 0;
    end else if (hold_off == 0 && expected_results.size() == 10) begin
      m_ready  <= 1'b0;
      hold_off <= 80;
    end else if (hold_off > 1) begin
      hold_off <= hold_off - 1;
    end else begin
      hold_off <= (hold_off == 1) ? -1 : hold_off;
      case ($urandom_range(0, 3))
        0: m_ready <= 1'b1;
        1: m_ready <= $urandom_range(0, 3) != 0;
        2: m_ready <= ($urandom_range(0, 1) == 0);
        default: m_ready <= 1'b1;
      endcase
    end
  end

  // monitor: predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    out_t got;
    out_t exp_r;
    if (rst_n) begin
      if (m_valid && m_ready) begin
        got = out_t'('0);
        got.result      = m_data[31:0];
        got.store_data  = m_data[63:32];
        got.br_taken    = m_data[64];
        got.jump_target = m_data[96:65];
        got.csr_out     = m_data[160:97];
        got.error       = m_data[161];
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (got.result !== exp_r.result) begin
            $error("result: expected %h got %h", exp_r.result, got.result);
            fail_count++;
          end
          if (got.store_data !== exp_r.store_data) begin
            $error("store_data: expected %h got %h", exp_r.store_data, got.store_data);
            fail_count++;
          end
          if (got.br_taken !== exp_r.br_taken) begin
            $error("br_taken: expected %b got %b", exp_r.br_taken, got.br_taken);
            fail_count++;
          end
          if (got.jump_target !== exp_r.jump_target) begin
            $error("jump_target: expected %h got %h", exp_r.jump_target, got.jump_target);
            fail_count++;
          end
          if (got.csr_out !== exp_r.csr_out) begin
            $error("csr_out: expected %h got %h", exp_r.csr_out, got.csr_out);
            fail_count++;
          end
          if (got.error !== exp_r.error) begin
            $error("error: expected %b got %b", exp_r.error, got.error);
            fail_count++;
          end
        end
      end
      if (s_valid && s_ready) expected_results.push_back(execute_instr(unpack_in(s_data)));
    end
  end

  // end of run once everything has drained
  initial begin
    wait (rst_n);
    wait (stim_done && pending_instrs.size() == 0 && !s_valid);
    wait (expected_results.size() == 0);
    repeat (Latency * 3) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
